### rtl/amf3_pkg.sv
// Shared types, constants and compare helpers for the 3x3 adaptive median filter.
package amf3_pkg;

   localparam int PIXEL_BITS = 8;
   localparam int WIDTH_BITS = 11;
   localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = WIDTH_BITS'(512);

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] filtered_pixel;
      logic       row_end;
   } rsp_payload_type;

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pixel_type min3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic pixel_type max3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(max2(a, b), c);
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

### rtl/adaptive_median_filter_3x3_top.sv
// Pipeline: read, window, column sort, reduce, median, output register.
// Throughput: one pixel per cycle while the skid stage is empty; the two line
// stores are read at transfer and written back as the item leaves the read
// stage, with forwarding on a repeated column. Reset: synchronous; clears the
// pipeline, column position, row count; line_width to 512; line stores kept.
module adaptive_median_filter_3x3_top
   import amf3_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_wr_en,
   input  logic [WIDTH_BITS-1:0] csr_wr_data
);

   localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_BITS = ($clog2(MAX_WIDTH + 1) > WIDTH_BITS) ?
                             $clog2(MAX_WIDTH + 1) : WIDTH_BITS;
   localparam logic [CMP_BITS-1:0] MAX_LAST = CMP_BITS'(MAX_WIDTH - 1);
   localparam logic [CMP_BITS-1:0] MIN_LAST = CMP_BITS'(2);

   // configuration
   logic [WIDTH_BITS-1:0] line_width_ff;
   logic [CMP_BITS-1:0]   width_ext;
   logic [CMP_BITS-1:0]   last_col;

   // position tracking
   logic [COL_BITS-1:0]   col_ff, col_in, col_cur;
   logic [1:0]            rows_ff, rows_in, rows_cur;
   logic                  is_last, is_emit;

   logic                  adv;
   logic                  req_xfer;
   pixel_type             px_in;

   // line stores
   pixel_type             upper_mem [MAX_WIDTH];
   pixel_type             middle_mem [MAX_WIDTH];
   pixel_type             upper_rd_ff, middle_rd_ff;

   // read stage
   logic                  s1_valid_ff, s1_emit_ff, s1_last_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   pixel_type             s1_px_ff;
   logic                  fwd_ff, fwd_in;
   pixel_type             fwd_top_ff, fwd_mid_ff;
   pixel_type             s1_top, s1_mid;

   pixel_type             win_ff [6];

   // window stage
   logic                  s2_valid_ff, s2_last_ff;
   pixel_type             s2_win_ff [9];
   pixel_type             s2_ctr_ff;

   // column sort stage
   logic                  s3_valid_ff, s3_last_ff;
   pixel_type             s3_lo_ff [3];
   pixel_type             s3_md_ff [3];
   pixel_type             s3_hi_ff [3];
   pixel_type             s3_ctr_ff;

   // reduce stage
   logic                  s4_valid_ff, s4_last_ff;
   pixel_type             s4_lo_ff, s4_hi_ff, s4_a_ff, s4_b_ff, s4_c_ff, s4_ctr_ff;

   // median stage
   logic                  s5_valid_ff, s5_last_ff;
   pixel_type             s5_lo_ff, s5_hi_ff, s5_med_ff, s5_ctr_ff;
   pixel_type             s5_res;

   // output and skid
   logic                  main_valid_ff, skid_valid_ff;
   rsp_payload_type       main_ff, skid_ff, res_in;
   logic                  pop, push;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
      end else if (csr_wr_en) begin
         line_width_ff <= csr_wr_data;
      end
   end

   assign width_ext = CMP_BITS'(line_width_ff);

   always_comb begin
      if (width_ext < CMP_BITS'(3)) begin
         last_col = MIN_LAST;
      end else if (width_ext > CMP_BITS'(MAX_WIDTH)) begin
         last_col = MAX_LAST;
      end else begin
         last_col = width_ext - CMP_BITS'(1);
      end
   end

   assign adv       = !skid_valid_ff;
   assign req_ready = adv;
   assign req_xfer  = req_valid && req_ready;
   assign px_in     = PIXEL_BITS'(req_payload.pixel_value);

   assign col_cur  = req_payload.frame_start ? '0 : col_ff;
   assign rows_cur = req_payload.frame_start ? 2'd0 : rows_ff;
   assign is_last  = CMP_BITS'(col_cur) >= last_col;
   assign is_emit  = (rows_cur == 2'd2) && (col_cur >= COL_BITS'(2));
   assign col_in   = is_last ? '0 : col_cur + COL_BITS'(1);
   assign rows_in  = (is_last && rows_cur != 2'd2) ? rows_cur + 2'd1 : rows_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         rows_ff <= 2'd0;
      end else if (req_xfer) begin
         col_ff  <= col_in;
         rows_ff <= rows_in;
      end
   end

   assign s1_top = fwd_ff ? fwd_top_ff : upper_rd_ff;
   assign s1_mid = fwd_ff ? fwd_mid_ff : middle_rd_ff;
   assign fwd_in = req_xfer && s1_valid_ff && (s1_col_ff == col_cur);

   // read at transfer, write back as the item leaves the read stage
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         upper_rd_ff  <= upper_mem[col_cur];
         middle_rd_ff <= middle_mem[col_cur];
      end
      if (adv && s1_valid_ff) begin
         upper_mem[s1_col_ff]  <= s1_mid;
         middle_mem[s1_col_ff] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_xfer;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff  <= col_cur;
         s1_px_ff   <= px_in;
         s1_emit_ff <= is_emit;
         s1_last_ff <= is_last;
         fwd_top_ff <= s1_mid;
         fwd_mid_ff <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= s1_top;
         win_ff[4] <= s1_mid;
         win_ff[5] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 6; i++) begin
            s2_win_ff[i] <= win_ff[i];
         end
         s2_win_ff[6] <= s1_top;
         s2_win_ff[7] <= s1_mid;
         s2_win_ff[8] <= s1_px_ff;
         s2_ctr_ff    <= win_ff[4];
         s2_last_ff   <= s1_last_ff;

         for (int c = 0; c < 3; c++) begin
            s3_lo_ff[c] <= min3(s2_win_ff[3*c], s2_win_ff[3*c+1], s2_win_ff[3*c+2]);
            s3_md_ff[c] <= med3(s2_win_ff[3*c], s2_win_ff[3*c+1], s2_win_ff[3*c+2]);
            s3_hi_ff[c] <= max3(s2_win_ff[3*c], s2_win_ff[3*c+1], s2_win_ff[3*c+2]);
         end
         s3_ctr_ff  <= s2_ctr_ff;
         s3_last_ff <= s2_last_ff;

         s4_lo_ff   <= min3(s3_lo_ff[0], s3_lo_ff[1], s3_lo_ff[2]);
         s4_a_ff    <= max3(s3_lo_ff[0], s3_lo_ff[1], s3_lo_ff[2]);
         s4_b_ff    <= med3(s3_md_ff[0], s3_md_ff[1], s3_md_ff[2]);
         s4_c_ff    <= min3(s3_hi_ff[0], s3_hi_ff[1], s3_hi_ff[2]);
         s4_hi_ff   <= max3(s3_hi_ff[0], s3_hi_ff[1], s3_hi_ff[2]);
         s4_ctr_ff  <= s3_ctr_ff;
         s4_last_ff <= s3_last_ff;

         s5_lo_ff   <= s4_lo_ff;
         s5_hi_ff   <= s4_hi_ff;
         s5_med_ff  <= med3(s4_a_ff, s4_b_ff, s4_c_ff);
         s5_ctr_ff  <= s4_ctr_ff;
         s5_last_ff <= s4_last_ff;
      end
   end

   always_comb begin
      if (s5_lo_ff < s5_med_ff && s5_med_ff < s5_hi_ff) begin
         s5_res = (s5_lo_ff < s5_ctr_ff && s5_ctr_ff < s5_hi_ff) ? s5_ctr_ff : s5_med_ff;
      end else begin
         s5_res = s5_ctr_ff;
      end
   end

   assign res_in.filtered_pixel = 8'(s5_res);
   assign res_in.row_end        = s5_last_ff;

   assign pop  = main_valid_ff && rsp_ready;
   assign push = adv && s5_valid_ff;

   // hold a result in the skid stage while the main register is blocked
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || pop) begin
         main_ff <= skid_valid_ff ? skid_ff : res_in;
      end else if (push) begin
         skid_ff <= res_in;
      end
   end

   assign rsp_valid   = main_valid_ff;
   assign rsp_payload = main_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> main_valid_ff)
      else $error("skid stage full while output register empty");

   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> !req_ready)
      else $error("input transfer allowed while skid stage full");

   assert property (@(posedge clock) disable iff (reset) fwd_ff |-> s1_valid_ff)
      else $error("forwarding flagged without an item in the read stage");

   assert property (@(posedge clock) disable iff (reset)
                    (skid_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("blocked result lost from skid stage");

   assert property (@(posedge clock) disable iff (reset) rows_ff != 2'd3)
      else $error("row count passed saturation");
`endif

endmodule

### verif/adaptive_median_filter_3x3_top_tb.sv
// Testbench for the 3x3 adaptive median filter: scoreboard class, stimulus tasks, checks.
module adaptive_median_filter_3x3_top_tb;
   import amf3_pkg::*;

   localparam int MAX_COLS = 1024;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 3000000;

   typedef enum int {MIX_UNIFORM, MIX_IMPULSE, MIX_LEVELS, MIX_FLAT} pixel_mix_type;

   class filter_scoreboard_type;
      pixel_type upper_row[MAX_COLS];
      pixel_type middle_row[MAX_COLS];
      pixel_type columns[6];
      int unsigned col_pos;
      int unsigned rows_done;
      logic [WIDTH_BITS-1:0] line_width;
      rsp_payload_type expected_pixels[$];
      int unsigned mismatches;

      function new();
         foreach (upper_row[i]) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         foreach (columns[i]) columns[i] = '0;
         col_pos = 0;
         rows_done = 0;
         line_width = LINE_WIDTH_RESET;
         mismatches = 0;
      endfunction

      function int unsigned clamp_width(logic [WIDTH_BITS-1:0] v);
         if (v < 3) return 3;
         if (v > MAX_COLS) return MAX_COLS;
         return 32'(v);
      endfunction

      function int unsigned active_width();
         return clamp_width(line_width);
      endfunction

      function void set_width(logic [WIDTH_BITS-1:0] v);
         line_width = v;
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      function void note_pixel(req_payload_type px_in);
         pixel_type win[9];
         pixel_type top, mid, centre, key, lo, med, hi;
         rsp_payload_type item;
         int unsigned w, col;
         bit last_col, interior;
         int i, j;
         w = active_width();
         if (px_in.frame_start) begin
            col_pos = 0;
            rows_done = 0;
         end
         col = (col_pos >= MAX_COLS) ? MAX_COLS - 1 : col_pos;
         top = upper_row[col];
         mid = middle_row[col];
         upper_row[col] = mid;
         middle_row[col] = px_in.pixel_value;
         for (i = 0; i < 6; i++) win[i] = columns[i];
         win[6] = top;
         win[7] = mid;
         win[8] = px_in.pixel_value;
         centre = columns[4];
         for (i = 0; i < 3; i++) columns[i] = columns[i+3];
         columns[3] = top;
         columns[4] = mid;
         columns[5] = px_in.pixel_value;
         last_col = (col_pos + 1 >= w);
         interior = (rows_done >= 2) && (col_pos >= 2);
         if (last_col) begin
            col_pos = 0;
            if (rows_done < 2) rows_done++;
         end else begin
            col_pos++;
         end
         if (!interior) return;
         for (i = 1; i < 9; i++) begin
            key = win[i];
            j = i - 1;
            while (j >= 0 && win[j] > key) begin
               win[j+1] = win[j];
               j--;
            end
            win[j+1] = key;
         end
         lo = win[0];
         med = win[4];
         hi = win[8];
         if (lo < med && med < hi)
            item.filtered_pixel = (lo < centre && centre < hi) ? centre : med;
         else
            item.filtered_pixel = centre;
         item.row_end = last_col;
         expected_pixels.push_back(item);
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_pixels.size() == 0) begin
            $error("unexpected transfer: filtered_pixel=%0d row_end=%0b",
                   got.filtered_pixel, got.row_end);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         if (got.filtered_pixel !== want.filtered_pixel) begin
            $error("filtered_pixel: expected %0d, actual %0d",
                   want.filtered_pixel, got.filtered_pixel);
            mismatches++;
         end
         if (got.row_end !== want.row_end) begin
            $error("row_end: expected %0b, actual %0b", want.row_end, got.row_end);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [WIDTH_BITS-1:0] csr_wr_data = '0;

   filter_scoreboard_type sb = new();
   bit long_hold_req = 1'b0;
   int unsigned cycle_count = 0;

   pixel_type directed_pixels[24] = '{
      8'd0,   8'd255, 8'd0,
      8'd255, 8'd128, 8'd255,
      8'd0,   8'd255, 8'd0,
      8'd7,   8'd7,   8'd7,
      8'd7,   8'd7,   8'd7,
      8'd9,   8'd9,   8'd9,
      8'd9,   8'd200, 8'd9,
      8'd9,   8'd9,   8'd9
   };

   adaptive_median_filter_3x3_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("adaptive_median_filter_3x3_top_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
   end

   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic pixel_type next_pixel(input pixel_mix_type mix, input pixel_type base);
      int unsigned r;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_UNIFORM: return pixel_type'($urandom);
         MIX_IMPULSE: begin
            if (r < 8) return '0;
            if (r < 16) return '1;
            return base + pixel_type'($urandom_range(0, 3));
         end
         MIX_LEVELS: begin
            if (r < 33) return '0;
            if (r < 66) return base;
            return '1;
         end
         default: return (r < 4) ? pixel_type'($urandom) : base;
      endcase
   endfunction

   // Hold ready low for a long stretch once on request; otherwise idle at random.
   initial begin
      int unsigned stall_left;
      int unsigned burst_left;
      bit hold_taken;
      stall_left = 0;
      burst_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = LONG_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (burst_left > 0)
               burst_left--;
            else if ($urandom_range(0, 63) == 0)
               burst_left = $urandom_range(30, 120);
            else
               stall_left = idle_gap();
         end
      end
   end

   task automatic send_pixel(input pixel_type pix, input logic fs, input int unsigned gap);
      req_payload_type item;
      item.pixel_value = pix;
      item.frame_start = fs;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_pixel(item);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_BITS-1:0] v);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_width(v);
   endtask

   task automatic run_phase(input logic [WIDTH_BITS-1:0] width_code, input int unsigned count,
                            input bit restart, input bit hold_rsp, input bit pause_mid);
      pixel_mix_type mix;
      pixel_type base;
      bit no_idle;
      logic fs;
      int unsigned k;
      write_width(width_code);
      mix = pixel_mix_type'($urandom_range(0, 3));
      base = pixel_type'($urandom);
      no_idle = ($urandom_range(0, 3) == 0);
      if (hold_rsp) long_hold_req = 1'b1;
      for (k = 0; k < count; k++) begin
         if (pause_mid && k == count / 2) drain();
         fs = (k == 0 && restart) ||
              (sb.active_width() <= 64 && $urandom_range(0, 149) == 0);
         send_pixel(next_pixel(mix, base), fs, no_idle ? 0 : idle_gap());
      end
   endtask

   initial begin
      logic [WIDTH_BITS-1:0] small_widths[14];
      logic [WIDTH_BITS-1:0] width_code;
      int unsigned i, p, w;
      bit restart;
      small_widths = '{0, 1, 2, 3, 4, 5, 6, 7, 9, 12, 16, 23, 40, 64};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_width(0);
      for (i = 0; i < 24; i++) send_pixel(directed_pixels[i], i == 0, idle_gap());

      for (p = 0; p < 8; p++) begin
         width_code = (p == 3) ? 11'd3 : small_widths[$urandom_range(0, 13)];
         w = sb.clamp_width(width_code);
         restart = (w > sb.active_width()) || ($urandom_range(0, 1) == 1);
         run_phase(width_code, (p == 3) ? 300 : 3 * w + $urandom_range(10, 40),
                   restart, p == 3, p == 6);
      end

      run_phase(11'd2047, 150 + $urandom_range(0, 30), 1'b1, 1'b0, 1'b0);
      run_phase(11'd1024, 60, 1'b0, 1'b0, 1'b0);
      run_phase(11'd5, 80, 1'b0, 1'b0, 1'b0);

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("adaptive_median_filter_3x3_top_tb: PASS");
      end else begin
         $display("adaptive_median_filter_3x3_top_tb: FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/amf3_pkg.sv
rtl/adaptive_median_filter_3x3_top.sv
verif/adaptive_median_filter_3x3_top_tb.sv
